[src/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked even during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[src/kf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kf_pkg
// shared widths, register indexes and arithmetic helpers for the filter
// ----------------------------------------------------------------------------
package kf_pkg;

   localparam int unsigned DataWidth = 32;
   localparam int unsigned CsrIndexWidth = 2;

   localparam logic [16:0] TimeStepReset = 17'd6554;
   localparam logic [30:0] ProcNoiseReset = 31'd655;
   localparam logic [30:0] MeasNoiseReset = 31'd6554;
   localparam logic [30:0] InitUncertReset = 31'd6553600;

   localparam logic [CsrIndexWidth-1:0] CSR_TIME_STEP = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_PROC_NOISE = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_MEAS_NOISE = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_INIT_UNCERT = 2'd3;

   localparam int unsigned DivSteps = 48;

   // saturate a 33-bit sum to 32 bits
   function automatic logic signed [31:0] sat_add(input logic signed [32:0] v);
      logic signed [31:0] r;
      begin
         if (v[32] != v[31]) r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
         else r = v[31:0];
         return r;
      end
   endfunction

   // saturate a 48-bit quantity to 32 bits
   function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
      logic signed [31:0] r;
      begin
         if (v > 48'sh0000_7fff_ffff) r = 32'sh7fff_ffff;
         else if (v < -48'sh0000_8000_0000) r = 32'sh8000_0000;
         else r = v[31:0];
         return r;
      end
   endfunction

endpackage

[src/kf_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kf_div
// restoring signed divider, one quotient bit per cycle, truncates toward zero
// and saturates the quotient to 32 bits
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module kf_div
   import kf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [47:0]  numer,
   input  logic signed [33:0]  denom,
   output logic                done,
   output logic signed [31:0]  quot
);

   logic [47:0] rem_mag_ff, rem_mag_in;
   logic [47:0] q_ff, q_in;
   logic [33:0] d_ff, d_in;
   logic        neg_ff, neg_in;
   logic        busy_ff, busy_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        done_ff, done_in;
   logic [48:0] part;
   logic [48:0] trial;

   assign part  = {rem_mag_ff, q_ff[47]};
   assign trial = part - {15'd0, d_ff};

   always_comb begin
      rem_mag_in = rem_mag_ff;
      q_in = q_ff;
      d_in = d_ff;
      neg_in = neg_ff;
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_mag_in = '0;
         q_in = numer[47] ? 48'(-numer) : numer;
         d_in = denom[33] ? 34'(-denom) : denom;
         neg_in = numer[47] ^ denom[33];
         busy_in = 1'b1;
         cnt_in = '0;
      end else if (busy_ff) begin
         if (!trial[48]) begin
            rem_mag_in = trial[47:0];
            q_in = {q_ff[46:0], 1'b1};
         end else begin
            rem_mag_in = part[47:0];
            q_in = {q_ff[46:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(DivSteps - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_mag_ff <= rem_mag_in;
      q_ff <= q_in;
      d_ff <= d_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;
   // magnitude is unsigned, so clamp before applying the sign
   assign quot = neg_ff
                 ? ((q_ff > 48'h0000_8000_0000) ? 32'sh8000_0000 : 32'(-q_ff))
                 : ((q_ff > 48'h0000_7fff_ffff) ? 32'sh7fff_ffff : q_ff[31:0]);

   `ASSERT_CLK(a_done_after_busy, clock, reset, done_ff |-> $past(busy_ff), "done without busy")
   `ASSERT_CLK(a_no_start_busy, clock, reset, busy_ff |-> !start, "divider restarted")
   `ASSERT_CLK(a_start_busy, clock, reset, start |=> busy_ff, "no busy after start")

endmodule

[src/kalman_filter_pos_vel.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kalman_filter_pos_vel
// two-state constant-velocity kalman filter, q16.16 fixed point
// ----------------------------------------------------------------------------
// usage:
//   req_ carries a measured position and a control acceleration. each
//   transaction runs one predict/correct step and produces one rsp_
//   transaction with position, velocity and position variance.
//   csr_ writes dt, process noise, measurement noise and initial
//   uncertainty; write only while idle. reset reloads the default initial
//   uncertainty into the covariance diagonal, so a written value does not
//   reach the state.
//   one shared 32x32 multiplier runs under a sequencer: 12 products, plus
//   two passes of a 48-step restoring divider for the gains (none when the
//   innovation variance is zero). req_ready returns in the cycle after the
//   result transaction, so a new request is not taken until the last
//   result has been accepted. a stalled receiver holds the result and
//   req_ready stays low; nothing is lost.
//   reset clears position, velocity and the off-diagonal covariance.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module kalman_filter_pos_vel
   import kf_pkg::*;
#(
   parameter logic [16:0] TIME_STEP_RST = TimeStepReset
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [31:0]        req_measured_position,
   input  logic signed [31:0]        req_control_accel,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [31:0]        rsp_est_position,
   output logic signed [31:0]        rsp_est_velocity,
   output logic [30:0]               rsp_position_variance,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CsrIndexWidth-1:0]  csr_index,
   input  logic [31:0]               csr_data
);

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_DIV_START, S_DIV_WAIT, S_OUT
   } state_type;

   state_type state_ff;
   logic [4:0] step_ff;

   logic [16:0] dt_ff;
   logic [30:0] q_ff, r_ff;
   logic signed [31:0] pe_ff, ve_ff, cpp_ff, cpv_ff, cvv_ff;
   logic signed [31:0] z_ff, u_ff;
   // working registers
   logic signed [31:0] h_ff, pp_ff, vp_ff, a01_ff, a00_ff, p00_ff, p11_ff;
   logic signed [31:0] k0_ff, k1_ff, y_ff;
   logic               t_ff;
   logic signed [63:0] prod_ff;
   logic signed [33:0] s_sum;

   // shared multiplier operands
   logic signed [31:0] ma, mb;
   logic signed [63:0] prod;
   logic signed [47:0] qtr;   // product / 65536 truncated
   logic signed [31:0] mq;
   logic signed [31:0] hh;

   logic div_start, div_done;
   logic signed [31:0] div_q;
   logic signed [47:0] div_n;

   always_comb begin
      ma = 32'sd0;
      mb = 32'sd0;
      case (step_ff)
         5'd0:  begin ma = {15'd0, dt_ff}; mb = {15'd0, dt_ff}; end
         5'd1:  begin ma = {15'd0, dt_ff}; mb = ve_ff; end
         5'd2:  begin ma = h_ff; mb = u_ff; end
         5'd3:  begin ma = {15'd0, dt_ff}; mb = u_ff; end
         5'd4:  begin ma = {15'd0, dt_ff}; mb = cvv_ff; end
         5'd5:  begin ma = {15'd0, dt_ff}; mb = cpv_ff; end
         5'd6:  begin ma = {15'd0, dt_ff}; mb = a01_ff; end
         5'd7:  begin ma = k0_ff; mb = y_ff; end
         5'd8:  begin ma = k1_ff; mb = y_ff; end
         5'd9:  begin ma = k0_ff; mb = p00_ff; end
         5'd10: begin ma = k0_ff; mb = a01_ff; end
         5'd11: begin ma = k1_ff; mb = a01_ff; end
         default: begin ma = 32'sd0; mb = 32'sd0; end
      endcase
   end

   assign prod = ma * mb;
   // truncate toward zero
   assign qtr = (prod_ff[63] && (prod_ff[15:0] != 16'd0))
                ? 48'(prod_ff[63:16] + 48'sd1) : prod_ff[63:16];
   assign mq = sat48(qtr);
   assign hh = sat48((prod_ff[63] && (prod_ff[16:0] != 17'd0))
                ? 48'({{1{prod_ff[63]}}, prod_ff[63:17]} + 48'sd1)
                : 48'({{1{prod_ff[63]}}, prod_ff[63:17]}));

   assign div_n = step_ff[0] ? {a01_ff, 16'd0} : {p00_ff, 16'd0};
   // innovation variance, kept exact
   assign s_sum = 34'(p00_ff) + 34'(signed'({1'b0, r_ff}));

   kf_div u_div (
      .clock (clock), .reset (reset), .start (div_start),
      .numer (div_n), .denom (s_sum), .done (div_done), .quot (div_q)
   );

   assign div_start = (state_ff == S_DIV_START) && (s_sum != 34'sd0);
   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_est_position = pe_ff;
   assign rsp_est_velocity = ve_ff;
   assign rsp_position_variance = cpp_ff[31] ? 31'd0 : cpp_ff[30:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff <= '0;
         t_ff <= 1'b0;
         dt_ff <= TIME_STEP_RST;
         q_ff <= ProcNoiseReset;
         r_ff <= MeasNoiseReset;
         pe_ff <= '0;
         ve_ff <= '0;
         cpv_ff <= '0;
         cpp_ff <= {1'b0, InitUncertReset};
         cvv_ff <= {1'b0, InitUncertReset};
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_TIME_STEP:   dt_ff <= csr_data[16:0];
               CSR_PROC_NOISE:  q_ff <= csr_data[30:0];
               CSR_MEAS_NOISE:  r_ff <= csr_data[30:0];
               // reset restores the default diagonal
               CSR_INIT_UNCERT: ;
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  z_ff <= req_measured_position;
                  u_ff <= req_control_accel;
                  step_ff <= 5'd0;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               // even phase: multiply; odd phase: consume product
               if (!t_ff) begin
                  prod_ff <= prod;
                  t_ff <= 1'b1;
               end else begin
                  t_ff <= 1'b0;
                  if (step_ff == 5'd6) step_ff <= 5'd0;
                  else step_ff <= step_ff + 5'd1;
                  case (step_ff)
                     5'd0: h_ff <= hh;
                     5'd1: pp_ff <= sat_add(33'(pe_ff) + 33'(mq));
                     5'd2: pp_ff <= sat_add(33'(pp_ff) + 33'(mq));
                     5'd3: vp_ff <= sat_add(33'(ve_ff) + 33'(mq));
                     5'd4: a01_ff <= sat_add(33'(cpv_ff) + 33'(mq));
                     5'd5: a00_ff <= sat_add(33'(cpp_ff) + 33'(mq));
                     5'd6: begin
                        p00_ff <= sat_add(33'(sat_add(33'(a00_ff) + 33'(mq)))
                                  + 33'(signed'({1'b0, q_ff})));
                        p11_ff <= sat_add(33'(cvv_ff) + 33'(signed'({1'b0, q_ff})));
                        y_ff <= sat_add(33'(z_ff) - 33'(pp_ff));
                        state_ff <= S_DIV_START;
                     end
                     5'd7: pe_ff <= sat_add(33'(pp_ff) + 33'(mq));
                     5'd8: ve_ff <= sat_add(33'(vp_ff) + 33'(mq));
                     5'd9: cpp_ff <= sat_add(33'(p00_ff) - 33'(mq));
                     5'd10: cpv_ff <= sat_add(33'(a01_ff) - 33'(mq));
                     5'd11: begin
                        cvv_ff <= sat_add(33'(p11_ff) - 33'(mq));
                        state_ff <= S_OUT;
                     end
                     default: ;
                  endcase
               end
            end
            S_DIV_START: begin
               // zero innovation variance: both gains are zero
               if (s_sum == 34'sd0) begin
                  k0_ff <= '0;
                  k1_ff <= '0;
                  step_ff <= 5'd7;
                  state_ff <= S_MUL;
               end else begin
                  state_ff <= S_DIV_WAIT;
               end
            end
            S_DIV_WAIT: begin
               if (div_done) begin
                  if (step_ff == 5'd0) begin
                     k0_ff <= div_q;
                     step_ff <= 5'd1;
                     state_ff <= S_DIV_START;
                  end else begin
                     k1_ff <= div_q;
                     step_ff <= 5'd7;
                     state_ff <= S_MUL;
                  end
               end
            end
            S_OUT: begin
               if (rsp_ready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `ASSERT_CLK(a_rsp_only_out, clock, reset, rsp_valid |-> !req_ready, "result and ready together")
   `ASSERT_CLK(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> rsp_valid, "result dropped")
   `ASSERT_CLK(a_accept_starts, clock, reset, (req_valid && req_ready) |=> !req_ready, "no busy after accept")

endmodule
